// ===== hdl/sccb_register_write_master_core_defines.svh =====
// Assertion macros for the SCCB write master checker.
// No dependencies; included by the checker file.
`ifndef SCCB_REGISTER_WRITE_MASTER_CORE_DEFINES_SVH
`define SCCB_REGISTER_WRITE_MASTER_CORE_DEFINES_SVH

// Clocked assertion that is ignored while reset is asserted.
`define SCCBWM_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Clocked assertion that also holds during reset.
`define SCCBWM_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ===== hdl/sccbwm_pkg.sv =====
// Shared types and constants of the SCCB write master.
// No dependencies; imported by every module of the block.
package sccbwm_pkg;

  localparam int DelayBitsDef = 16;
  localparam int CfgIdxW      = 1;
  localparam int CfgDataW     = 16;
  localparam int WaitW        = 16;
  localparam int RetryW       = 5;

  localparam logic [WaitW-1:0]  WaitTicksRst  = WaitW'(100);
  localparam logic [RetryW-1:0] RetryLimitRst = RetryW'(20);

  localparam logic [CfgIdxW-1:0] CfgWaitTicks  = CfgIdxW'(0);
  localparam logic [CfgIdxW-1:0] CfgRetryLimit = CfgIdxW'(1);

  typedef struct packed {
    logic       command;
    logic [7:0] device_id;
    logic [7:0] register_address;
    logic [7:0] write_data;
    logic       sda_sample;
  } sccbwm_in_t;

  typedef struct packed {
    logic              scl_level;
    logic              sda_level;
    logic              sda_drive;
    logic              busy_res;
    logic              done_res;
    logic              failed;
    logic [RetryW-1:0] attempts_used;
  } sccbwm_out_t;

  typedef struct packed {
    logic [WaitW-1:0]  wait_ticks;
    logic [RetryW-1:0] retry_limit;
  } sccbwm_cfg_t;

endpackage

// ===== hdl/sccbwm_cfg.sv =====
// Configuration registers of the SCCB write master.
// Depends on sccbwm_pkg.
module sccbwm_cfg
  import sccbwm_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_valid_i,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  output logic                cfg_ready_o,
  output sccbwm_cfg_t         cfg_o
);

  sccbwm_cfg_t cfg_q, cfg_d;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (cfg_index_i)
        CfgWaitTicks:  cfg_d.wait_ticks  = cfg_data_i[WaitW-1:0];
        CfgRetryLimit: cfg_d.retry_limit = cfg_data_i[RetryW-1:0];
        default:       cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.wait_ticks  <= WaitTicksRst;
      cfg_q.retry_limit <= RetryLimitRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== hdl/sccbwm_seq.sv =====
// Bus sequencer of the SCCB write master: phase state, counters, pin state
// and the one-tick next-state logic. Depends on sccbwm_pkg.
module sccbwm_seq
  import sccbwm_pkg::*;
#(
  parameter int DelayBits = DelayBitsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  sccbwm_cfg_t cfg_i,
  input  logic        step_en_i,
  input  sccbwm_in_t  item_i,
  output sccbwm_out_t result_o
);

  localparam logic [3:0] PhIdle     = 4'd0;
  localparam logic [3:0] PhStartA   = 4'd1;
  localparam logic [3:0] PhStartB   = 4'd2;
  localparam logic [3:0] PhBitSetup = 4'd3;
  localparam logic [3:0] PhBitHigh  = 4'd4;
  localparam logic [3:0] PhBitHold  = 4'd5;
  localparam logic [3:0] PhAckSetup = 4'd6;
  localparam logic [3:0] PhAckHigh  = 4'd7;
  localparam logic [3:0] PhAckHold  = 4'd8;
  localparam logic [3:0] PhNackHold = 4'd9;
  localparam logic [3:0] PhStopA    = 4'd10;
  localparam logic [3:0] PhStopB    = 4'd11;
  localparam logic [3:0] PhStopC    = 4'd12;

  localparam int WideW = (DelayBits > WaitW) ? DelayBits : WaitW;

  logic [3:0]           phase_q, phase_d;
  logic [1:0]           byte_idx_q, byte_idx_d;
  logic [3:0]           bit_idx_q, bit_idx_d;
  logic [7:0]           shift_q, shift_d;
  logic [DelayBits-1:0] delay_q, delay_d;
  logic [RetryW-1:0]    attempt_q, attempt_d;
  logic                 scl_q, scl_d, sda_q, sda_d, drv_q, drv_d;
  logic                 fail_q, fail_d;
  logic [7:0]           bytes_q [3];
  logic                 done;

  logic [WideW-1:0]     wait_wide;
  logic [DelayBits-1:0] load;
  logic [RetryW-1:0]    lim;
  logic [1:0]           byte_next;
  logic [3:0]           bit_next;
  logic [1:0]           sel_idx;
  logic [7:0]           sel_byte;

  // Segment length: zero acts as one, values beyond the counter saturate.
  always_comb begin
    wait_wide = WideW'(cfg_i.wait_ticks);
    if (cfg_i.wait_ticks == '0) begin
      load = DelayBits'(1);
    end else if (wait_wide > WideW'({DelayBits{1'b1}})) begin
      load = {DelayBits{1'b1}};
    end else begin
      load = wait_wide[DelayBits-1:0];
    end
  end

  assign lim       = (cfg_i.retry_limit == '0) ? RetryW'(1) : cfg_i.retry_limit;
  assign byte_next = byte_idx_q + 2'd1;
  assign bit_next  = bit_idx_q + 4'd1;
  assign sel_idx   = (phase_q == PhAckHold) ? byte_next : byte_idx_q;

  always_comb begin
    case (sel_idx)
      2'd0:    sel_byte = bytes_q[0];
      2'd1:    sel_byte = bytes_q[1];
      2'd2:    sel_byte = bytes_q[2];
      default: sel_byte = bytes_q[0];
    endcase
  end

  always_comb begin
    phase_d    = phase_q;
    byte_idx_d = byte_idx_q;
    bit_idx_d  = bit_idx_q;
    shift_d    = shift_q;
    delay_d    = delay_q;
    attempt_d  = attempt_q;
    scl_d      = scl_q;
    sda_d      = sda_q;
    drv_d      = drv_q;
    fail_d     = fail_q;
    done       = 1'b0;

    if (phase_q == PhIdle) begin
      if (item_i.command) begin
        attempt_d  = RetryW'(1);
        fail_d     = 1'b0;
        byte_idx_d = 2'd0;
        bit_idx_d  = 4'd0;
        {scl_d, sda_d, drv_d} = 3'b111;
        phase_d    = PhStartA;
        delay_d    = load;
      end
    end else if (delay_q > DelayBits'(1)) begin
      delay_d = delay_q - DelayBits'(1);
    end else begin
      case (phase_q)
        PhStartA: begin
          {scl_d, sda_d, drv_d} = 3'b101;
          phase_d = PhStartB;
          delay_d = load;
        end
        PhStartB: begin
          bit_idx_d = 4'd0;
          {scl_d, sda_d, drv_d} = {1'b0, sel_byte[7], 1'b1};
          shift_d   = {sel_byte[6:0], 1'b0};
          phase_d   = PhBitSetup;
          delay_d   = load;
        end
        PhBitSetup: begin
          scl_d   = 1'b1;
          phase_d = PhBitHigh;
          delay_d = load;
        end
        PhBitHigh: begin
          scl_d   = 1'b0;
          phase_d = PhBitHold;
          delay_d = load;
        end
        PhBitHold: begin
          bit_idx_d = bit_next;
          if (!bit_next[3]) begin
            {scl_d, sda_d, drv_d} = {1'b0, shift_q[7], 1'b1};
            shift_d = {shift_q[6:0], 1'b0};
            phase_d = PhBitSetup;
          end else begin
            // Release SDA so the device can acknowledge.
            {scl_d, sda_d, drv_d} = 3'b010;
            phase_d = PhAckSetup;
          end
          delay_d = load;
        end
        PhAckSetup: begin
          scl_d   = 1'b1;
          phase_d = PhAckHigh;
          delay_d = load;
        end
        PhAckHigh: begin
          scl_d   = 1'b0;
          phase_d = item_i.sda_sample ? PhNackHold : PhAckHold;
          delay_d = load;
        end
        PhAckHold: begin
          byte_idx_d = byte_next;
          if (byte_next != 2'd3) begin
            bit_idx_d = 4'd0;
            {scl_d, sda_d, drv_d} = {1'b0, sel_byte[7], 1'b1};
            shift_d   = {sel_byte[6:0], 1'b0};
            phase_d   = PhBitSetup;
          end else begin
            {scl_d, sda_d, drv_d} = 3'b001;
            phase_d = PhStopA;
          end
          delay_d = load;
        end
        PhNackHold: begin
          if (attempt_q < lim) begin
            // Retry from a fresh start condition, no stop in between.
            attempt_d  = attempt_q + RetryW'(1);
            byte_idx_d = 2'd0;
            bit_idx_d  = 4'd0;
            {scl_d, sda_d, drv_d} = 3'b111;
            phase_d    = PhStartA;
            delay_d    = load;
          end else begin
            fail_d  = 1'b1;
            phase_d = PhIdle;
            delay_d = '0;
            done    = 1'b1;
          end
        end
        PhStopA: begin
          scl_d   = 1'b1;
          phase_d = PhStopB;
          delay_d = load;
        end
        PhStopB: begin
          sda_d   = 1'b1;
          drv_d   = 1'b1;
          phase_d = PhStopC;
          delay_d = load;
        end
        PhStopC: begin
          fail_d  = 1'b0;
          phase_d = PhIdle;
          delay_d = '0;
          done    = 1'b1;
        end
        default: begin
          phase_d = PhIdle;
          delay_d = '0;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PhIdle;
      byte_idx_q <= 2'd0;
      bit_idx_q  <= 4'd0;
      shift_q    <= 8'd0;
      delay_q    <= '0;
      attempt_q  <= '0;
      scl_q      <= 1'b1;
      sda_q      <= 1'b1;
      drv_q      <= 1'b1;
      fail_q     <= 1'b0;
    end else if (step_en_i) begin
      phase_q    <= phase_d;
      byte_idx_q <= byte_idx_d;
      bit_idx_q  <= bit_idx_d;
      shift_q    <= shift_d;
      delay_q    <= delay_d;
      attempt_q  <= attempt_d;
      scl_q      <= scl_d;
      sda_q      <= sda_d;
      drv_q      <= drv_d;
      fail_q     <= fail_d;
    end
  end

  // The byte store is written on every start before it is read.
  always_ff @(posedge clk_i) begin
    if (step_en_i && (phase_q == PhIdle) && item_i.command) begin
      bytes_q[0] <= item_i.device_id;
      bytes_q[1] <= item_i.register_address;
      bytes_q[2] <= item_i.write_data;
    end
  end

  always_comb begin
    result_o.scl_level     = scl_d;
    result_o.sda_level     = sda_d;
    result_o.sda_drive     = drv_d;
    result_o.busy_res      = (phase_d != PhIdle);
    result_o.done_res      = done;
    result_o.failed        = fail_d;
    result_o.attempts_used = attempt_d;
  end

endmodule

// ===== hdl/sccb_register_write_master_core.sv =====
// SCCB write master, one bus tick per input word, one result word per tick.
// An accepted word passes the input register, then the result register.
// Throughput: one word per cycle while the output is not stalled; the
// sequencer step is a single pass of logic between the two registers.
// Reset clears all control state; pins go to SCL high, SDA high and driven.
module sccb_register_write_master_core
  import sccbwm_pkg::*;
#(
  parameter int DelayBits = DelayBitsDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  sccbwm_in_t          in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output sccbwm_out_t         out_data_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  sccbwm_cfg_t cfg;
  sccbwm_out_t result;
  sccbwm_in_t  in_data_q;
  sccbwm_out_t out_data_q;
  logic        in_valid_q, in_valid_d;
  logic        out_valid_q, out_valid_d;
  logic        advance, accept, fire;

  // The result register frees up when it is empty or its word is taken.
  assign advance    = !out_valid_q || !out_stall_i;
  assign in_stall_o = in_valid_q && !advance;
  assign accept     = in_valid_i && !in_stall_o;
  assign fire       = in_valid_q && advance;

  assign in_valid_d  = accept ? 1'b1 : (fire ? 1'b0 : in_valid_q);
  assign out_valid_d = advance ? in_valid_q : out_valid_q;

  sccbwm_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_o       (cfg)
  );

  sccbwm_seq #(
    .DelayBits (DelayBits)
  ) u_seq (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg),
    .step_en_i (fire),
    .item_i    (in_data_q),
    .result_o  (result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      in_data_q <= in_data_i;
    end
    if (fire) begin
      out_data_q <= result;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

// ===== hdl/sccbwm_checker.sv =====
// Port-level checker for the SCCB write master, bound to the top level.
// Depends on sccbwm_pkg and sccb_register_write_master_core_defines.svh.
`include "sccb_register_write_master_core_defines.svh"

module sccbwm_checker
  import sccbwm_pkg::*;
(
  input logic                clk_i,
  input logic                rst_ni,
  input logic                out_valid_o,
  input logic                out_stall_i,
  input sccbwm_out_t         out_data_o
);

  // A stalled result word stays put.
  `SCCBWM_ASSERT(a_out_hold, out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o), "stalled result word changed")

  // The end of a transaction is never reported while still busy.
  `SCCBWM_ASSERT(a_done_idle, out_valid_o && out_data_o.done_res |-> !out_data_o.busy_res, "done reported while busy")

  // A released data line reads as high.
  `SCCBWM_ASSERT(a_release_high, out_valid_o && !out_data_o.sda_drive |-> out_data_o.sda_level, "released SDA not shown high")

  // After a failure no stop was sent: SCL stays low and SDA stays released.
  `SCCBWM_ASSERT(a_fail_pins, out_valid_o && out_data_o.failed |-> !out_data_o.busy_res && !out_data_o.scl_level && !out_data_o.sda_drive, "pins wrong after failure")

  // A busy transaction has always begun at least one attempt.
  `SCCBWM_ASSERT(a_busy_attempt, out_valid_o && out_data_o.busy_res |-> out_data_o.attempts_used != '0, "busy without an attempt")

endmodule

bind sccb_register_write_master_core sccbwm_checker u_sccbwm_checker (.*);

// ===== tb/sccb_register_write_master_core_test.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for the SCCB register write master core.
// Needs sccbwm_pkg and the core; every result word is checked against a built-in predictor or the opening script.
module sccb_register_write_master_core_test;
  import sccbwm_pkg::*;

  localparam logic CmdTick  = 1'b0;
  localparam logic CmdStart = 1'b1;
  localparam logic SdaAck   = 1'b0;
  localparam logic SdaNack  = 1'b1;

  localparam int CycleLimit = 1_000_000;
  localparam int HoldCycles = 300;
  localparam int Latency    = 2;

  typedef enum logic [3:0] {
    SeqIdle, SeqStartA, SeqStartB, SeqBitSetup, SeqBitHigh, SeqBitHold, SeqAckSetup,
    SeqAckHigh, SeqAckHold, SeqNackHold, SeqStopA, SeqStopB, SeqStopC
  } seq_phase_e;

  typedef struct packed {
    sccbwm_in_t  word;
    logic [5:0]  reps;
    logic        typed;
    sccbwm_out_t want;
  } script_row_t;

  // Runs with wait_ticks and retry_limit at zero, so both act as one. The first
  // attempt gets a NACK on the device byte and the transfer ends as failed.
  localparam int OpeningRows = 7;
  localparam script_row_t OpeningScript [OpeningRows] = '{
    '{'{CmdTick, 8'h00, 8'h00, 8'h00, SdaAck}, 6'd1, 1'b1,
      '{1'b1, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 5'd0}},
    '{'{CmdStart, 8'hFF, 8'h00, 8'hFF, SdaNack}, 6'd1, 1'b1,
      '{1'b1, 1'b1, 1'b1, 1'b1, 1'b0, 1'b0, 5'd1}},
    '{'{CmdStart, 8'h00, 8'hFF, 8'h00, SdaAck}, 6'd1, 1'b0, '0},
    '{'{CmdTick, 8'h5A, 8'hA5, 8'h3C, SdaAck}, 6'd26, 1'b0, '0},
    '{'{CmdTick, 8'h00, 8'h00, 8'h00, SdaNack}, 6'd1, 1'b1,
      '{1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b0, 5'd1}},
    '{'{CmdTick, 8'h00, 8'h00, 8'h00, SdaAck}, 6'd1, 1'b1,
      '{1'b0, 1'b1, 1'b0, 1'b0, 1'b1, 1'b1, 5'd1}},
    '{'{CmdTick, 8'hFF, 8'hFF, 8'hFF, SdaAck}, 6'd1, 1'b1,
      '{1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b1, 5'd1}}
  };

  logic                clk_i       = 1'b0;
  logic                rst_ni      = 1'b0;
  logic                in_valid_i  = 1'b0;
  logic                in_stall_o;
  sccbwm_in_t          in_data_i   = '0;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  sccbwm_out_t         out_data_o;
  logic                cfg_valid_i = 1'b0;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i = '0;
  logic [CfgDataW-1:0] cfg_data_i  = '0;

  // Predictor state.
  seq_phase_e   phase_q;
  logic [1:0]   byte_sel;
  logic [3:0]   bit_cnt;
  logic [7:0]   shifter;
  logic [15:0]  ticks_left;
  logic [4:0]   tries;
  logic [7:0]   held_bytes [3];
  logic         scl, sda, drv, fail;
  logic [15:0]  cfg_wait;
  logic [4:0]   cfg_retry;

  sccbwm_out_t  bus_status_due [$];
  sccbwm_out_t  head_word;
  int           mismatches = 0;
  int           words_sent = 0;
  logic         quiet      = 1'b0;
  logic         hold_req   = 1'b0;
  int           stall_left = 0;

  sccb_register_write_master_core dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  function automatic void enter_phase(input seq_phase_e p);
    phase_q    = p;
    ticks_left = (cfg_wait == 16'd0) ? 16'd1 : cfg_wait;
  endfunction

  function automatic void put_bit();
    scl     = 1'b0;
    sda     = shifter[7];
    drv     = 1'b1;
    shifter = shifter << 1;
    enter_phase(SeqBitSetup);
  endfunction

  function automatic void fetch_byte();
    shifter = held_bytes[byte_sel];
    bit_cnt = 4'd0;
    put_bit();
  endfunction

  function automatic void open_attempt();
    byte_sel = 2'd0;
    bit_cnt  = 4'd0;
    scl      = 1'b1;
    sda      = 1'b1;
    drv      = 1'b1;
    enter_phase(SeqStartA);
  endfunction

  // Advances the sequencer by one tick and returns the status word it shows.
  function automatic sccbwm_out_t bus_tick(input sccbwm_in_t w);
    sccbwm_out_t r;
    logic [4:0]  lim;
    logic        ended;
    lim   = (cfg_retry == 5'd0) ? 5'd1 : cfg_retry;
    ended = 1'b0;
    if (phase_q == SeqIdle) begin
      if (w.command == CmdStart) begin
        held_bytes[0] = w.device_id;
        held_bytes[1] = w.register_address;
        held_bytes[2] = w.write_data;
        tries = 5'd1;
        fail  = 1'b0;
        open_attempt();
      end
    end else if (ticks_left > 16'd1) begin
      ticks_left = ticks_left - 16'd1;
    end else begin
      case (phase_q)
        SeqStartA: begin
          scl = 1'b1;
          sda = 1'b0;
          drv = 1'b1;
          enter_phase(SeqStartB);
        end
        SeqStartB: fetch_byte();
        SeqBitSetup: begin
          scl = 1'b1;
          enter_phase(SeqBitHigh);
        end
        SeqBitHigh: begin
          scl = 1'b0;
          enter_phase(SeqBitHold);
        end
        SeqBitHold: begin
          bit_cnt = bit_cnt + 4'd1;
          if (bit_cnt < 4'd8) begin
            put_bit();
          end else begin
            scl = 1'b0;
            sda = 1'b1;
            drv = 1'b0;
            enter_phase(SeqAckSetup);
          end
        end
        SeqAckSetup: begin
          scl = 1'b1;
          enter_phase(SeqAckHigh);
        end
        SeqAckHigh: begin
          scl = 1'b0;
          enter_phase((w.sda_sample == SdaNack) ? SeqNackHold : SeqAckHold);
        end
        SeqAckHold: begin
          byte_sel = byte_sel + 2'd1;
          if (byte_sel < 2'd3) begin
            fetch_byte();
          end else begin
            scl = 1'b0;
            sda = 1'b0;
            drv = 1'b1;
            enter_phase(SeqStopA);
          end
        end
        SeqNackHold: begin
          // A NACK restarts with a fresh start condition, no stop in between.
          if (tries < lim) begin
            tries = tries + 5'd1;
            open_attempt();
          end else begin
            fail       = 1'b1;
            phase_q    = SeqIdle;
            ticks_left = 16'd0;
            ended      = 1'b1;
          end
        end
        SeqStopA: begin
          scl = 1'b1;
          enter_phase(SeqStopB);
        end
        SeqStopB: begin
          sda = 1'b1;
          drv = 1'b1;
          enter_phase(SeqStopC);
        end
        SeqStopC: begin
          fail       = 1'b0;
          phase_q    = SeqIdle;
          ticks_left = 16'd0;
          ended      = 1'b1;
        end
        default: begin
          phase_q    = SeqIdle;
          ticks_left = 16'd0;
        end
      endcase
    end
    r.scl_level     = scl;
    r.sda_level     = sda;
    r.sda_drive     = drv;
    r.busy_res      = (phase_q != SeqIdle);
    r.done_res      = ended;
    r.failed        = fail;
    r.attempts_used = tries;
    return r;
  endfunction

  function automatic sccbwm_in_t random_word(input logic cmd, input int nack_pct);
    sccbwm_in_t w;
    w.command          = cmd;
    w.device_id        = 8'($urandom);
    w.register_address = 8'($urandom);
    w.write_data       = 8'($urandom);
    w.sda_sample       = ($urandom_range(0, 99) < nack_pct) ? SdaNack : SdaAck;
    return w;
  endfunction

  // Offers one word, waits for it to be taken, then queues its expected result.
  task automatic send_word(input sccbwm_in_t w, input logic typed, input sccbwm_out_t want);
    sccbwm_out_t calc;
    if (!quiet && $urandom_range(0, 99) < 7) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= w;
    do @(posedge clk_i); while (in_stall_o);
    calc = bus_tick(w);
    bus_status_due.push_back(typed ? want : calc);
    words_sent++;
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (bus_status_due.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    wait_drained();
    repeat (Latency + 2) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    if (idx == CfgWaitTicks) cfg_wait = data;
    else cfg_retry = data[4:0];
  endtask

  // One write transaction from start until the sequencer is idle again, with
  // a few idle ticks ahead of it and the odd start while busy inside it.
  task automatic run_transfer(input int nack_pct);
    logic cmd;
    repeat ($urandom_range(0, 2)) send_word(random_word(CmdTick, 50), 1'b0, '0);
    send_word(random_word(CmdStart, nack_pct), 1'b0, '0);
    while (phase_q != SeqIdle) begin
      cmd = ($urandom_range(0, 99) < 3) ? CmdStart : CmdTick;
      send_word(random_word(cmd, nack_pct), 1'b0, '0);
    end
  endtask

  task automatic run_transfers(input int budget);
    int stop_at;
    int pct;
    stop_at = words_sent + budget;
    while (words_sent < stop_at) begin
      case ($urandom_range(0, 4))
        0, 1: pct = 0;
        2: pct = 15;
        3: pct = 40;
        default: pct = 70;
      endcase
      run_transfer(pct);
    end
  endtask

  task automatic check_field(input string name, input logic [4:0] want, input logic [4:0] got);
    if (want !== got) begin
      mismatches++;
      $display("%0t ns: %s expected %0d, got %0d", $time, name, want, got);
    end
  endtask

  // Receiver: random stall bursts, plus one long hold-off on request.
  always @(posedge clk_i) begin
    if (hold_req) begin
      hold_req    <= 1'b0;
      stall_left  <= HoldCycles;
      out_stall_i <= 1'b1;
    end else if (stall_left > 1) begin
      stall_left <= stall_left - 1;
    end else if (stall_left == 1) begin
      stall_left  <= 0;
      out_stall_i <= 1'b0;
    end else if (!quiet && $urandom_range(0, 99) < 8) begin
      stall_left  <= $urandom_range(1, 12);
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (bus_status_due.size() == 0) begin
        mismatches++;
        $display("%0t ns: result word %h arrived with none expected", $time, out_data_o);
      end else begin
        head_word = bus_status_due.pop_front();
        check_field("scl_level", head_word.scl_level, out_data_o.scl_level);
        check_field("sda_level", head_word.sda_level, out_data_o.sda_level);
        check_field("sda_drive", head_word.sda_drive, out_data_o.sda_drive);
        check_field("busy_res", head_word.busy_res, out_data_o.busy_res);
        check_field("done_res", head_word.done_res, out_data_o.done_res);
        check_field("failed", head_word.failed, out_data_o.failed);
        check_field("attempts_used", head_word.attempts_used, out_data_o.attempts_used);
      end
    end
  end

  initial begin
    for (int n = 0; n < CycleLimit; n++) @(posedge clk_i);
    $display("TB_ERROR");
    $finish;
  end

  initial begin
    phase_q    = SeqIdle;
    byte_sel   = 2'd0;
    bit_cnt    = 4'd0;
    shifter    = 8'd0;
    ticks_left = 16'd0;
    tries      = 5'd0;
    held_bytes = '{8'd0, 8'd0, 8'd0};
    scl        = 1'b1;
    sda        = 1'b1;
    drv        = 1'b1;
    fail       = 1'b0;
    cfg_wait   = WaitTicksRst;
    cfg_retry  = RetryLimitRst;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    write_reg(CfgWaitTicks, 16'd0);
    write_reg(CfgRetryLimit, 16'd0);
    for (int i = 0; i < OpeningRows; i++)
      repeat (OpeningScript[i].reps)
        send_word(OpeningScript[i].word, OpeningScript[i].typed, OpeningScript[i].want);

    // The receiver holds off for a long stretch while words keep coming.
    write_reg(CfgWaitTicks, 16'd1);
    write_reg(CfgRetryLimit, 16'd3);
    run_transfer(0);
    hold_req <= 1'b1;
    run_transfers(200);

    // The sender pauses once until every result word is back.
    write_reg(CfgWaitTicks, 16'd2);
    write_reg(CfgRetryLimit, 16'd1);
    run_transfers(100);
    wait_drained();
    run_transfers(100);

    // Largest retry limit, transfer NACKed on every attempt.
    write_reg(CfgWaitTicks, 16'd1);
    write_reg(CfgRetryLimit, 16'd31);
    run_transfer(100);

    // Upper data bits are dropped, so the retry limit is zero here.
    write_reg(CfgWaitTicks, 16'd0);
    write_reg(CfgRetryLimit, 16'hFFE0);
    run_transfers(150);

    quiet = 1'b1;
    write_reg(CfgWaitTicks, 16'd1);
    write_reg(CfgRetryLimit, 16'd2);
    run_transfers(150);

    // Longest segment: the counter loads its full range and counts down.
    write_reg(CfgWaitTicks, 16'hFFFF);
    send_word(random_word(CmdStart, 50), 1'b0, '0);
    repeat (40) send_word(random_word(CmdTick, 50), 1'b0, '0);

    wait_drained();
    repeat (Latency + 6) @(posedge clk_i);
    if (mismatches == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

endmodule
